### rtl/scnf_pkg.sv
package scnf_pkg;

    localparam int DELAY_DEPTH = 2048;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int PERIOD_W    = 11;
    localparam int ENABLE_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int PROD_W      = 32;
    localparam int STEP_W      = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(960);
    localparam logic [ENABLE_W-1:0] ENABLE_RESET = 2'b11;

    // Q15 coefficients, held as 17-bit signed so they stay positive
    localparam logic signed [16:0] COEF_B = 17'sd31785;
    localparam logic signed [16:0] COEF_R = 17'sd30802;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 1'b1;

    // step conditions: hold the step until the condition is met
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_IN_VALID = 2'd1;
    localparam logic [1:0] COND_OUT_FREE = 2'd2;

    localparam logic CH_LEFT  = 1'b0;
    localparam logic CH_RIGHT = 1'b1;

    typedef struct packed {
        logic [1:0] cond;
        logic       restart;   // go back to step 0 instead of stepping on
        logic       latch_in;  // capture samples, issue delay-line read
        logic       mul_en;
        logic       mul_fb;    // 0: b * x, 1: r * y
        logic       mul_ch;
        logic       ld_x0;
        logic       x0_ch;
        logic       ld_y;
        logic       y_ch;
        logic       ld_w;
        logic       w_ch;
        logic       commit;    // write delay line, advance pointer, load output
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_status_t;

    function automatic ctrl_word_t microcode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '0;
        case (step)
            3'd0:
            begin
                w.cond     = COND_IN_VALID;
                w.latch_in = 1'b1;
            end
            3'd1:
            begin
                w.mul_en = 1'b1;
                w.mul_ch = CH_LEFT;
            end
            3'd2:
            begin
                w.ld_x0  = 1'b1;
                w.x0_ch  = CH_LEFT;
                w.mul_en = 1'b1;
                w.mul_ch = CH_RIGHT;
            end
            3'd3:
            begin
                w.ld_x0 = 1'b1;
                w.x0_ch = CH_RIGHT;
                w.ld_y  = 1'b1;
                w.y_ch  = CH_LEFT;
            end
            3'd4:
            begin
                w.ld_y   = 1'b1;
                w.y_ch   = CH_RIGHT;
                w.mul_en = 1'b1;
                w.mul_fb = 1'b1;
                w.mul_ch = CH_LEFT;
            end
            3'd5:
            begin
                w.ld_w   = 1'b1;
                w.w_ch   = CH_LEFT;
                w.mul_en = 1'b1;
                w.mul_fb = 1'b1;
                w.mul_ch = CH_RIGHT;
            end
            3'd6:
            begin
                w.ld_w = 1'b1;
                w.w_ch = CH_RIGHT;
            end
            default:
            begin
                w.cond    = COND_OUT_FREE;
                w.commit  = 1'b1;
                w.restart = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
            return 16'sh7fff;
        else if (v < -18'sd32768)
            return 16'sh8000;
        else
            return v[SAMPLE_W-1:0];
    endfunction

endpackage

### rtl/stereo_comb_notch_filter.sv
// The 8-step microprogram runs both channels through one shared 17x16 multiplier,
// and a new stereo pair is taken only once the previous one has been committed.
// A stalled output holds the last step until the result register is taken.
// Reset (async, active low): pointer and fill flag clear, delay = 960, both channels
// enabled; delay-line entries not written since reset read as zero.
module stereo_comb_notch_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [scnf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scnf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,  // left_in[15:0], right_in[31:16]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata   // left_out[15:0], right_out[31:16]
);
    import scnf_pkg::*;

    logic [PERIOD_W-1:0] delay_period_reg;
    logic [ENABLE_W-1:0] filter_enable_reg;
    logic                m_valid_reg;

    seq_status_t status;
    ctrl_word_t  act;

    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    assign status.in_valid = s_tvalid;
    assign status.out_free = !m_valid_reg || m_tready;

    scnf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .act      (act),
        .in_ready (s_tready)
    );

    scnf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .act           (act),
        .left_in       (s_tdata[SAMPLE_W-1:0]),
        .right_in      (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .delay_period  (delay_period_reg),
        .filter_enable (filter_enable_reg),
        .left_out      (left_out),
        .right_out     (right_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_period_reg  <= PERIOD_RESET;
            filter_enable_reg <= ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELAY_PERIOD:  delay_period_reg  <= cfg_data[PERIOD_W-1:0];
                REG_FILTER_ENABLE: filter_enable_reg <= cfg_data[ENABLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (act.commit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {right_out, left_out};

endmodule

### rtl/scnf_seq.sv
module scnf_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scnf_pkg::seq_status_t status,
    output scnf_pkg::ctrl_word_t  act,
    output logic                 in_ready
);
    import scnf_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_word_t        word;
    logic              go;

    assign word = microcode(step_reg);

    always_comb
    begin
        unique case (word.cond)
            COND_IN_VALID: go = status.in_valid;
            COND_OUT_FREE: go = status.out_free;
            default:       go = 1'b1;
        endcase
    end

    assign in_ready = (word.cond == COND_IN_VALID);
    assign act      = go ? word : '0;

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            if (word.restart)
                step_next = '0;
            else
                step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

endmodule

### rtl/scnf_dp.sv
module scnf_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scnf_pkg::ctrl_word_t                  act,
    input  logic signed [scnf_pkg::SAMPLE_W-1:0]  left_in,
    input  logic signed [scnf_pkg::SAMPLE_W-1:0]  right_in,
    input  logic [scnf_pkg::PERIOD_W-1:0]         delay_period,
    input  logic [scnf_pkg::ENABLE_W-1:0]         filter_enable,
    output logic signed [scnf_pkg::SAMPLE_W-1:0]  left_out,
    output logic signed [scnf_pkg::SAMPLE_W-1:0]  right_out
);
    import scnf_pkg::*;

    logic [2*SAMPLE_W-1:0] mem [DELAY_DEPTH];
    logic [2*SAMPLE_W-1:0] rdata_reg;

    logic [ADDR_W-1:0] wp_reg;
    logic              full_reg;
    logic              hit_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic signed [SAMPLE_W-1:0] xl_reg, xr_reg;
    logic signed [SAMPLE_W-1:0] x0l_reg, x0r_reg;
    logic signed [SAMPLE_W-1:0] yl_reg, yr_reg;
    logic signed [SAMPLE_W-1:0] wl_reg, wr_reg;
    logic signed [PROD_W-1:0]   p_reg;
    logic signed [SAMPLE_W-1:0] lo_reg, ro_reg;

    logic signed [16:0]         coef;
    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [32:0]         prod;
    logic signed [SAMPLE_W-1:0] q;
    logic signed [SAMPLE_W-1:0] d_sel;
    logic signed [SAMPLE_W-1:0] x0_y;
    logic signed [SAMPLE_W-1:0] x0_w;
    logic signed [SAMPLE_W-1:0] y_val;
    logic signed [SAMPLE_W-1:0] w_val;

    assign rd_addr = wp_reg - ADDR_W'(delay_period);

    // single shared multiplier
    assign coef   = act.mul_fb ? COEF_R : COEF_B;
    assign mul_op = act.mul_fb ? (act.mul_ch ? yr_reg : yl_reg)
                               : (act.mul_ch ? xr_reg : xl_reg);
    assign prod   = 33'(coef) * 33'(mul_op);
    // floor(p / 2^15); magnitude stays below 2^15 since coefficients are < 1
    assign q      = p_reg[SAMPLE_W+14:15];

    // entries not yet written since reset read as zero
    always_comb
    begin
        if (!hit_reg)
            d_sel = '0;
        else if (act.y_ch)
            d_sel = rdata_reg[2*SAMPLE_W-1:SAMPLE_W];
        else
            d_sel = rdata_reg[SAMPLE_W-1:0];
    end

    assign x0_y  = act.y_ch ? x0r_reg : x0l_reg;
    assign x0_w  = act.w_ch ? x0r_reg : x0l_reg;
    assign y_val = sat16(18'(x0_y) + 18'(d_sel));
    assign w_val = sat16(18'(q) - 18'(x0_w));

    always_ff @(posedge clk)
    begin
        if (act.commit)
            mem[wp_reg] <= {wr_reg, wl_reg};
        if (act.latch_in)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (act.latch_in)
                hit_reg <= full_reg || (rd_addr < wp_reg);
            if (act.commit)
            begin
                wp_reg <= wp_reg + ADDR_W'(1);
                if (wp_reg == ADDR_W'(DELAY_DEPTH - 1))
                    full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.latch_in)
        begin
            xl_reg <= left_in;
            xr_reg <= right_in;
        end
        if (act.mul_en)
            p_reg <= prod[PROD_W-1:0];
        if (act.ld_x0)
        begin
            if (act.x0_ch)
                x0r_reg <= q;
            else
                x0l_reg <= q;
        end
        if (act.ld_y)
        begin
            if (act.y_ch)
                yr_reg <= y_val;
            else
                yl_reg <= y_val;
        end
        if (act.ld_w)
        begin
            if (act.w_ch)
                wr_reg <= w_val;
            else
                wl_reg <= w_val;
        end
        if (act.commit)
        begin
            lo_reg <= filter_enable[0] ? yl_reg : xl_reg;
            ro_reg <= filter_enable[1] ? yr_reg : xr_reg;
        end
    end

    assign left_out  = lo_reg;
    assign right_out = ro_reg;

endmodule

### rtl/scnf_checker.sv
module scnf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // one pair in flight: no back-to-back input transactions
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous pair still in flight");

    // output valid is high one program length after every input transaction
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##8 m_tvalid)
        else $error("result missing after program run");

    // a new result only appears while the input side is busy
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no pair in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

endmodule

bind stereo_comb_notch_filter scnf_checker u_scnf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/stereo_comb_notch_filter_tb.sv
module stereo_comb_notch_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scnf_pkg::*;

    localparam int TOTAL_ITEMS  = 1150;
    localparam int MAX_IDLE     = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT  = 4000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } stereo_pair_t;

    class comb_scoreboard;
        logic signed [SAMPLE_W-1:0] delay_line [2][DELAY_DEPTH];
        int unsigned                wr_pos;
        logic [PERIOD_W-1:0]        delay_len;
        logic [ENABLE_W-1:0]        enable;
        stereo_pair_t               expected_pairs [$];
        int                         errors;

        function new();
            for (int i = 0; i < DELAY_DEPTH; i++)
            begin
                delay_line[CH_LEFT][i]  = '0;
                delay_line[CH_RIGHT][i] = '0;
            end
            wr_pos    = 0;
            delay_len = PERIOD_RESET;
            enable    = ENABLE_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_DELAY_PERIOD)
                delay_len = data[PERIOD_W-1:0];
            else if (idx == REG_FILTER_ENABLE)
                enable = data[ENABLE_W-1:0];
        endfunction

        function int clip16(int v);
            if (v > 32767)
                return 32767;
            else if (v < -32768)
                return -32768;
            return v;
        endfunction

        // Q15 product, floor rounding
        function int q15_mul(int coef, int v);
            int p;
            p = coef * v;
            return clip16(p >>> 15);
        endfunction

        function int run_channel(int ch, int unsigned rd, int x, bit en);
            int x0;
            int y;
            x0 = q15_mul(int'(COEF_B), x);
            y  = clip16(x0 + int'(delay_line[ch][rd]));
            // read above happens first, so zero delay sees the old entry
            delay_line[ch][wr_pos] = SAMPLE_W'(clip16(q15_mul(int'(COEF_R), y) - x0));
            return en ? y : x;
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
            int unsigned  rd;
            stereo_pair_t res;
            rd = (wr_pos + DELAY_DEPTH - (int'(delay_len) % DELAY_DEPTH)) % DELAY_DEPTH;
            res.left  = SAMPLE_W'(run_channel(CH_LEFT, rd, int'(l), enable[0]));
            res.right = SAMPLE_W'(run_channel(CH_RIGHT, rd, int'(r), enable[1]));
            wr_pos = (wr_pos + 1) % DELAY_DEPTH;
            expected_pairs.push_back(res);
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        task report_mismatch(string what, logic [15:0] exp_val, logic [15:0] got_val);
            $display("[%0t] mismatch %s: expected %h got %h", $realtime, what, exp_val, got_val);
            errors++;
        endtask

        task check_result(logic [31:0] data);
            stereo_pair_t exp_pair;
            stereo_pair_t got_pair;
            got_pair = data;
            if (expected_pairs.size() == 0)
            begin
                report_mismatch("unexpected output transaction", '0, data[15:0]);
            end
            else
            begin
                exp_pair = expected_pairs.pop_front();
                if (got_pair.left !== exp_pair.left)
                    report_mismatch("left_out", exp_pair.left, got_pair.left);
                if (got_pair.right !== exp_pair.right)
                    report_mismatch("right_out", exp_pair.right, got_pair.right);
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;

    comb_scoreboard sb;
    bit             in_idle_on;
    bit             out_idle_on;
    int             items_sent;

    stereo_comb_notch_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        sb.write_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(int delay_val, int enable_val);
        write_reg(REG_DELAY_PERIOD, delay_val);
        write_reg(REG_FILTER_ENABLE, enable_val);
        cfg_release();
    endtask

    task automatic send_pair(logic [15:0] l, logic [15:0] r);
        int gap;
        gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(l, r);
        items_sent++;
    endtask

    task automatic input_release();
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom();
    endtask

    // stop feeding, let the filter empty, then give it a few extra cycles
    task automatic drain_pipeline();
        int waited;
        waited = 0;
        input_release();
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    // output side: random stall before each transaction while out_idle_on is set
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_result(m_tdata);
        end
    end

    initial
    begin
        int delay_val;
        int enable_val;
        int n_items;
        int style;
        int amp;
        int half;

        sb          = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        items_sent  = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: full-scale corners with a one-sample comb
        apply_setting(1, 3);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff);
        send_pair(16'sh0000, 16'sh0000);
        send_pair(16'shffff, 16'sh0001);
        send_pair(16'sh0001, 16'shffff);
        send_pair(16'sh4000, 16'shc000);
        drain_pipeline();

        // channel bypass combinations; delay line keeps updating underneath
        for (int en = 0; en < 3; en++)
        begin
            apply_setting(2, en);
            send_pair(16'sh7fff, 16'sh8000);
            send_pair(16'sh5555, 16'shaaaa);
            send_pair(16'sh8000, 16'sh7fff);
            drain_pipeline();
        end

        // zero delay: read and write hit the same entry
        apply_setting(0, 3);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh1234, 16'shedcb);
        send_pair(16'sh8000, 16'sh7fff);
        drain_pipeline();

        // longest delay
        apply_setting(2047, 3);
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'shaaaa, 16'sh5555);
        drain_pipeline();

        while (items_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       delay_val = 0;
                1:       delay_val = 2047;
                2:       delay_val = 960;
                3:       delay_val = $urandom_range(0, 2047);
                default: delay_val = $urandom_range(1, 64);
            endcase
            enable_val  = $urandom_range(0, 3);
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            style       = $urandom_range(0, 2);
            amp         = $urandom_range(8000, 32767);
            half        = $urandom_range(1, 20);
            n_items     = $urandom_range(80, 180);
            apply_setting(delay_val, enable_val);
            for (int i = 0; i < n_items; i++)
            begin
                // square-wave style pumps the feedback toward saturation
                if (style == 0)
                    send_pair(((i / half) % 2) ? 16'(amp) : 16'(-amp),
                              ((i / half) % 2) ? 16'(-amp) : 16'(amp));
                else
                    send_pair(random_sample(), random_sample());
            end
            drain_pipeline();
        end

        if (sb.pending() != 0)
            sb.report_mismatch("results still outstanding", '0, 16'(sb.pending()));

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
